/* design/sphere_phong_pixel_shader_unit_defines.svh */
// Assertion macros for the sphere shader.
`ifndef SPHERE_PHONG_PIXEL_SHADER_UNIT_DEFINES_SVH
`define SPHERE_PHONG_PIXEL_SHADER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define SPPX_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sppx check failed");
`define SPPX_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sppx check failed");
`else
`define SPPX_ASSERT_NOW(lbl, ante, cons)
`define SPPX_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* design/sppx_pkg.sv */
package sppx_pkg;

  localparam int PIX_W   = 11;
  localparam int RAD_W   = 10;
  localparam int LPOS_W  = 13;
  localparam int RGB_W   = 24;
  localparam int COL_W   = 8;
  localparam int CIDX_W  = 3;

  localparam int ZIN_W   = 36;
  localparam int VEC_W   = 22;
  localparam int MAG_W   = VEC_W - 1;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int LIN_W   = SQ_W + 2;
  localparam int LEN_W   = LIN_W / 2;
  localparam int QF      = 15;
  localparam int NUM_W   = MAG_W + QF;
  localparam int DEN_W   = LEN_W + 1;
  localparam int UNIT_W  = 16;
  localparam int ONE_SH  = 14;
  localparam int ONE     = 16384;
  localparam int DOT_W   = 18;
  localparam int REFL_W  = 19;
  localparam int SPEC_W  = 15;
  localparam int POW_STEPS = 24;

  localparam int NORM_LAT  = 1 + 1 + LEN_W + 1 + QF + 1;
  localparam int LIGHT_LAT = 6 + POW_STEPS;

  localparam logic [31:0] FULL      = 32'd2130739200;
  localparam logic [31:0] HALF_BIAS = 32'd4177920;
  localparam logic [16:0] RECIP_255 = 17'd65794;
  localparam logic [15:0] SQ_255    = 16'd65025;

  localparam logic [RAD_W-1:0]         RST_RADIUS   = 10'd200;
  localparam logic signed [LPOS_W-1:0] RST_LIGHT_X  = -13'sd400;
  localparam logic signed [LPOS_W-1:0] RST_LIGHT_Y  = 13'sd0;
  localparam logic signed [LPOS_W-1:0] RST_LIGHT_Z  = 13'sd400;
  localparam logic [RGB_W-1:0]         RST_MATERIAL = 24'h00FF00;
  localparam logic [RGB_W-1:0]         RST_LIGHT    = 24'hFFB300;
  localparam logic [RGB_W-1:0]         RST_AMBIENT  = 24'h333333;

  typedef enum logic [CIDX_W-1:0] {
    REG_RADIUS   = 3'd0,
    REG_LIGHT_X  = 3'd1,
    REG_LIGHT_Y  = 3'd2,
    REG_LIGHT_Z  = 3'd3,
    REG_MATERIAL = 3'd4,
    REG_LIGHT    = 3'd5,
    REG_AMBIENT  = 3'd6
  } cfg_reg_t;

  typedef logic signed [VEC_W-1:0]  vcomp_t;
  typedef vcomp_t                   vec3_t [3];
  typedef logic signed [UNIT_W-1:0] ucomp_t;
  typedef ucomp_t                   unit3_t [3];

  typedef struct packed {
    logic valid;
    logic cov;
  } tag_t;

  // divide by 2^14, rounding toward zero
  function automatic logic signed [39:0] tdiv_one(input logic signed [39:0] a);
    logic [39:0] m;
    m = a[39] ? 40'(-a) : 40'(a);
    m = m >> ONE_SH;
    return a[39] ? -$signed(m) : $signed(m);
  endfunction

endpackage

/* design/sppx_delay.sv */
module sppx_delay #(
  parameter int W     = 1,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic         rst,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [W-1:0] line [DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) line[i] <= '0;
    end else begin
      line[0] <= din;
      for (int i = 1; i < DEPTH; i++) line[i] <= line[i-1];
    end
  end

  assign dout = line[DEPTH-1];

endmodule

/* design/sppx_sqrt.sv */
module sppx_sqrt #(
  parameter int IN_W = 36
) (
  input  logic              clk,
  input  logic [IN_W-1:0]   rad,
  output logic [IN_W/2-1:0] root
);

  localparam int OW = IN_W / 2;
  localparam int RW = OW + 2;

  logic [IN_W-1:0] src_r [1:OW];
  logic [RW-1:0]   rem_r [1:OW];
  logic [OW-1:0]   res_r [1:OW];

  for (genvar s = 0; s < OW; s++) begin : g_stage
    logic [IN_W-1:0] cur_src;
    logic [RW-1:0]   cur_rem, acc, trial;
    logic [OW-1:0]   cur_res;
    logic            ge;
    if (s == 0) begin : g_first
      assign cur_src = rad;
      assign cur_rem = '0;
      assign cur_res = '0;
    end else begin : g_rest
      assign cur_src = src_r[s];
      assign cur_rem = rem_r[s];
      assign cur_res = res_r[s];
    end
    assign acc   = {cur_rem[RW-3:0], cur_src[IN_W-1 -: 2]};
    assign trial = {cur_res, 2'b01};
    assign ge    = acc >= trial;
    always_ff @(posedge clk) begin
      src_r[s+1] <= cur_src << 2;
      rem_r[s+1] <= ge ? acc - trial : acc;
      res_r[s+1] <= {cur_res[OW-2:0], ge};
    end
  end

  assign root = res_r[OW];

endmodule

/* design/sppx_udiv.sv */
module sppx_udiv #(
  parameter int N_W = 36,
  parameter int D_W = 23,
  parameter int Q_W = 15
) (
  input  logic           clk,
  input  logic [N_W-1:0] num,
  input  logic [D_W-1:0] den,
  output logic [Q_W-1:0] quo
);

  logic [D_W-1:0] rem_r [1:Q_W];
  logic [D_W-1:0] den_r [1:Q_W];
  logic [Q_W-1:0] low_r [1:Q_W];
  logic [Q_W-1:0] q_r   [1:Q_W];

  for (genvar s = 0; s < Q_W; s++) begin : g_stage
    logic [D_W-1:0] cur_rem, cur_den;
    logic [Q_W-1:0] cur_low, cur_q;
    logic [D_W:0]   acc, dsub;
    logic           ge;
    if (s == 0) begin : g_first
      assign cur_rem = D_W'(num[N_W-1:Q_W]);
      assign cur_den = den;
      assign cur_low = num[Q_W-1:0];
      assign cur_q   = '0;
    end else begin : g_rest
      assign cur_rem = rem_r[s];
      assign cur_den = den_r[s];
      assign cur_low = low_r[s];
      assign cur_q   = q_r[s];
    end
    assign acc  = {cur_rem, cur_low[Q_W-1]};
    assign dsub = {1'b0, cur_den};
    assign ge   = acc >= dsub;
    always_ff @(posedge clk) begin
      rem_r[s+1] <= ge ? D_W'(acc - dsub) : D_W'(acc);
      den_r[s+1] <= cur_den;
      low_r[s+1] <= cur_low << 1;
      q_r[s+1]   <= {cur_q[Q_W-2:0], ge};
    end
  end

  assign quo = q_r[Q_W];

endmodule

/* design/sppx_norm.sv */
module sppx_norm import sppx_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  vec3_t  vin,
  output unit3_t uout
);

  localparam int PK_W = 3 * (MAG_W + 1);

  logic [MAG_W-1:0] magc [3];
  logic [MAG_W-1:0] mag1 [3];
  logic             neg1 [3];
  logic [SQ_W-1:0]  sq1  [3];
  logic [LIN_W-1:0] sum2;
  logic [LEN_W-1:0] len;
  logic [PK_W-1:0]  pk_in, pk_out;
  logic [MAG_W-1:0] magd [3];
  logic             negd [3];
  logic [NUM_W-1:0] num3 [3];
  logic [DEN_W-1:0] den3;
  logic             zero3;
  logic             neg3 [3];
  logic [QF-1:0]    quo  [3];
  logic [3:0]       fl_out;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      magc[k] = vin[k][VEC_W-1] ? MAG_W'(-vin[k]) : MAG_W'(vin[k]);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      mag1[k] <= magc[k];
      neg1[k] <= vin[k][VEC_W-1];
      sq1[k]  <= SQ_W'(magc[k]) * SQ_W'(magc[k]);
    end
    sum2 <= LIN_W'(sq1[0]) + LIN_W'(sq1[1]) + LIN_W'(sq1[2]);
  end

  sppx_sqrt #(.IN_W(LIN_W)) u_len (
    .clk  (clk),
    .rad  (sum2),
    .root (len)
  );

  assign pk_in = {neg1[2], mag1[2], neg1[1], mag1[1], neg1[0], mag1[0]};

  sppx_delay #(.W(PK_W), .DEPTH(1 + LEN_W)) u_pk_dly (
    .clk  (clk),
    .rst  (rst),
    .din  (pk_in),
    .dout (pk_out)
  );

  assign {negd[2], magd[2], negd[1], magd[1], negd[0], magd[0]} = pk_out;

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      num3[k] <= {magd[k], {QF{1'b0}}} + NUM_W'(len);
      neg3[k] <= negd[k];
    end
    den3  <= {len, 1'b0};
    zero3 <= len == '0;
  end

  for (genvar k = 0; k < 3; k++) begin : g_div
    sppx_udiv #(.N_W(NUM_W), .D_W(DEN_W), .Q_W(QF)) u_div (
      .clk (clk),
      .num (num3[k]),
      .den (den3),
      .quo (quo[k])
    );
  end

  sppx_delay #(.W(4), .DEPTH(QF)) u_fl_dly (
    .clk  (clk),
    .rst  (rst),
    .din  ({zero3, neg3[2], neg3[1], neg3[0]}),
    .dout (fl_out)
  );

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      if (fl_out[3]) begin
        uout[k] <= '0;
      end else if (fl_out[k]) begin
        uout[k] <= -$signed(UNIT_W'(quo[k]));
      end else begin
        uout[k] <= $signed(UNIT_W'(quo[k]));
      end
    end
  end

endmodule

/* design/sppx_light.sv */
module sppx_light import sppx_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  unit3_t                  n,
  input  unit3_t                  l,
  input  unit3_t                  v,
  output logic signed [DOT_W-1:0] dn,
  output logic [SPEC_W-1:0]       sp
);

  logic signed [31:0]       nl1 [3];
  unit3_t                   n1, l1, v1, n2, l2, v2, l3, v3, v4;
  logic signed [39:0]       dsum, dq;
  logic signed [DOT_W-1:0]  dn2r;
  logic signed [33:0]       dm [3];
  logic signed [34:0]       t3 [3];
  logic signed [39:0]       rq [3];
  logic signed [REFL_W-1:0] refl4 [3];
  logic signed [35:0]       rv5 [3];
  logic signed [39:0]       ssum, sq;
  logic [SPEC_W-1:0]        s6;
  logic [SPEC_W-1:0]        p_r [1:POW_STEPS];
  logic [SPEC_W-1:0]        s_r [1:POW_STEPS];

  // N.L
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) nl1[k] <= n[k] * l[k];
    n1 <= n;
    l1 <= l;
    v1 <= v;
  end

  assign dsum = 40'(nl1[0]) + 40'(nl1[1]) + 40'(nl1[2]);
  assign dq   = tdiv_one(dsum);

  always_ff @(posedge clk) begin
    dn2r <= DOT_W'(dq);
    n2   <= n1;
    l2   <= l1;
    v2   <= v1;
  end

  // reflection 2(N.L)N - L
  always_comb begin
    for (int k = 0; k < 3; k++) dm[k] = dn2r * n2[k];
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) t3[k] <= {dm[k], 1'b0};
    l3 <= l2;
    v3 <= v2;
  end

  always_comb begin
    for (int k = 0; k < 3; k++) rq[k] = tdiv_one(40'(t3[k]));
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) refl4[k] <= REFL_W'(rq[k]) - REFL_W'(l3[k]);
    v4 <= v3;
  end

  // R.V, clamped to [0, 1]
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) rv5[k] <= refl4[k] * v4[k];
  end

  assign ssum = 40'(rv5[0]) + 40'(rv5[1]) + 40'(rv5[2]);
  assign sq   = tdiv_one(ssum);

  always_ff @(posedge clk) begin
    if (sq < 0) begin
      s6 <= '0;
    end else if (sq > 40'(ONE)) begin
      s6 <= SPEC_W'(ONE);
    end else begin
      s6 <= SPEC_W'(sq);
    end
  end

  // 25th power, one multiply per stage
  for (genvar i = 0; i < POW_STEPS; i++) begin : g_pow
    logic [SPEC_W-1:0]   cur_p, cur_s;
    logic [2*SPEC_W-1:0] pm;
    if (i == 0) begin : g_first
      assign cur_p = s6;
      assign cur_s = s6;
    end else begin : g_rest
      assign cur_p = p_r[i];
      assign cur_s = s_r[i];
    end
    assign pm = cur_p * cur_s;
    always_ff @(posedge clk) begin
      p_r[i+1] <= pm[ONE_SH +: SPEC_W];
      s_r[i+1] <= cur_s;
    end
  end

  assign sp = p_r[POW_STEPS];

  sppx_delay #(.W(DOT_W), .DEPTH(4 + POW_STEPS)) u_dn_dly (
    .clk  (clk),
    .rst  (rst),
    .din  (dn2r),
    .dout (dn)
  );

endmodule

/* design/sphere_phong_pixel_shader_unit.sv */
// A new pixel may start every cycle.
// Rate is set by the pipeline itself: every square root, division and power
// step has a stage of its own, so the unit never reports busy.
// Results are strobed on done for one cycle; the receiver cannot stall.
// Synchronous reset empties the pipeline and restores the default radius, light and colour setup.
`include "sphere_phong_pixel_shader_unit_defines.svh"

module sphere_phong_pixel_shader_unit import sppx_pkg::*; #(
  parameter int MAX_RADIUS = 1023
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [PIX_W-1:0] pixel_x,
  input  logic signed [PIX_W-1:0] pixel_y,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CIDX_W-1:0]       cfg_index,
  input  logic [RGB_W-1:0]        cfg_data,
  output logic                    done,
  output logic                    covered,
  output logic [COL_W-1:0]        red,
  output logic [COL_W-1:0]        green,
  output logic [COL_W-1:0]        blue
);

  localparam int ZLAT = ZIN_W / 2;
  localparam int LAT  = 1 + 1 + ZLAT + 1 + NORM_LAT + LIGHT_LAT + 5;
  localparam int FD_W = 2 + 2 * PIX_W;

  logic [RAD_W-1:0]         radius;
  logic signed [LPOS_W-1:0] light_x, light_y, light_z;
  logic [RGB_W-1:0]         material_rgb, light_rgb, ambient_rgb;
  logic [RAD_W-1:0]         r_eff;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius       <= RST_RADIUS;
      light_x      <= RST_LIGHT_X;
      light_y      <= RST_LIGHT_Y;
      light_z      <= RST_LIGHT_Z;
      material_rgb <= RST_MATERIAL;
      light_rgb    <= RST_LIGHT;
      ambient_rgb  <= RST_AMBIENT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_RADIUS:   radius       <= cfg_data[RAD_W-1:0];
        REG_LIGHT_X:  light_x      <= $signed(cfg_data[LPOS_W-1:0]);
        REG_LIGHT_Y:  light_y      <= $signed(cfg_data[LPOS_W-1:0]);
        REG_LIGHT_Z:  light_z      <= $signed(cfg_data[LPOS_W-1:0]);
        REG_MATERIAL: material_rgb <= cfg_data;
        REG_LIGHT:    light_rgb    <= cfg_data;
        REG_AMBIENT:  ambient_rgb  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign r_eff = (int'(radius) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : radius;

  // coverage test and radicand
  logic [2*PIX_W-1:0]       xx, yy;
  logic [2*RAD_W-1:0]       rr;
  logic                     vf1, vf2, cov2;
  logic signed [PIX_W-1:0]  x1, y1, x2, y2;
  logic [2*PIX_W-1:0]       d2_1;
  logic [2*RAD_W-1:0]       rr1;
  logic [ZIN_W-1:0]         rad2;
  logic                     cov1;

  assign xx   = pixel_x * pixel_x;
  assign yy   = pixel_y * pixel_y;
  assign rr   = r_eff * r_eff;
  assign cov1 = d2_1 <= (2*PIX_W)'(rr1);

  always_ff @(posedge clk) begin
    if (rst) begin
      vf1 <= 1'b0;
      vf2 <= 1'b0;
    end else begin
      vf1 <= start && !busy;
      vf2 <= vf1;
    end
  end

  always_ff @(posedge clk) begin
    x1   <= pixel_x;
    y1   <= pixel_y;
    d2_1 <= xx + yy;
    rr1  <= rr;
    x2   <= x1;
    y2   <= y1;
    cov2 <= cov1;
    rad2 <= cov1 ? {(2*RAD_W)'((2*PIX_W)'(rr1) - d2_1), 16'b0} : '0;
  end

  logic [ZLAT-1:0]         z3;
  logic [FD_W-1:0]         fd_out;
  logic                    vd, cd;
  logic signed [PIX_W-1:0] xd, yd;

  sppx_sqrt #(.IN_W(ZIN_W)) u_zsqrt (
    .clk  (clk),
    .rad  (rad2),
    .root (z3)
  );

  sppx_delay #(.W(FD_W), .DEPTH(ZLAT)) u_front_dly (
    .clk  (clk),
    .rst  (rst),
    .din  ({vf2, cov2, x2, y2}),
    .dout (fd_out)
  );

  assign {vd, cd, xd, yd} = fd_out;

  // position, view, light and second-light vectors
  vcomp_t xf, yf, zf, rf, lxf, lyf, lzf;
  vec3_t  pv, vv, lv, l2v;
  tag_t   tag3, tag_a0;

  assign xf  = VEC_W'(xd) <<< 8;
  assign yf  = VEC_W'(yd) <<< 8;
  assign zf  = VEC_W'(z3);
  assign rf  = VEC_W'({r_eff, 8'b0});
  assign lxf = VEC_W'(light_x) <<< 8;
  assign lyf = VEC_W'(light_y) <<< 8;
  assign lzf = VEC_W'(light_z) <<< 8;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag3 <= '0;
    end else begin
      tag3 <= '{valid: vd, cov: cd};
    end
  end

  always_ff @(posedge clk) begin
    pv  <= '{xf, yf, zf};
    vv  <= '{-xf, -yf, (rf <<< 2) + rf - zf};
    lv  <= '{lxf - xf, lyf - yf, lzf - zf};
    l2v <= '{(rf <<< 1) - xf, -rf - yf, -zf};
  end

  unit3_t n_u, v_u, l_u, l2_u;

  sppx_norm u_norm_n  (.clk(clk), .rst(rst), .vin(pv),  .uout(n_u));
  sppx_norm u_norm_v  (.clk(clk), .rst(rst), .vin(vv),  .uout(v_u));
  sppx_norm u_norm_l  (.clk(clk), .rst(rst), .vin(lv),  .uout(l_u));
  sppx_norm u_norm_l2 (.clk(clk), .rst(rst), .vin(l2v), .uout(l2_u));

  sppx_delay #(.W($bits(tag_t)), .DEPTH(NORM_LAT + LIGHT_LAT)) u_tag_dly (
    .clk  (clk),
    .rst  (rst),
    .din  (tag3),
    .dout (tag_a0)
  );

  logic signed [DOT_W-1:0] dn1, dn2;
  logic [SPEC_W-1:0]       sp1_raw, sp2_raw;

  sppx_light u_light_main (
    .clk (clk), .rst (rst), .n (n_u), .l (l_u), .v (v_u),
    .dn  (dn1), .sp (sp1_raw)
  );

  sppx_light u_light_grey (
    .clk (clk), .rst (rst), .n (n_u), .l (l2_u), .v (v_u),
    .dn  (dn2), .sp (sp2_raw)
  );

  // colour accumulation per channel
  tag_t              tag1, tag2, tag4_r, tag3_r;
  logic [16:0]       dif1_a, dif2_a;
  logic [SPEC_W-1:0] sp1_a, sp2_a;
  logic [15:0]       ml1 [3];
  logic [15:0]       am1 [3];
  logic [15:0]       lc1 [3];
  logic [15:0]       m1  [3];
  logic [32:0]       p2 [3];
  logic [30:0]       p3 [3];
  logic [32:0]       p4 [3];
  logic [30:0]       p5 [3];
  logic [35:0]       t1 [3];
  logic [35:0]       t2 [3];
  logic [35:0]       t3 [3];
  logic [35:0]       t4 [3];
  logic [35:0]       t5 [3];
  logic [35:0]       tsum [3];
  logic [31:0]       acc3 [3];
  logic [16:0]       tt4 [3];
  logic [33:0]       pr [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      tag1   <= '0;
      tag2   <= '0;
      tag3_r <= '0;
      tag4_r <= '0;
    end else begin
      tag1   <= tag_a0;
      tag2   <= tag1;
      tag3_r <= tag2;
      tag4_r <= tag3_r;
    end
  end

  always_ff @(posedge clk) begin
    dif1_a <= dn1[DOT_W-1] ? '0 : dn1[16:0];
    dif2_a <= dn2[DOT_W-1] ? '0 : dn2[16:0];
    sp1_a  <= sp1_raw;
    sp2_a  <= dn2[DOT_W-1] ? '0 : sp2_raw;
    for (int c = 0; c < 3; c++) begin
      ml1[c] <= material_rgb[8*(2-c) +: 8] * light_rgb[8*(2-c) +: 8];
      am1[c] <= ambient_rgb[8*(2-c) +: 8] * material_rgb[8*(2-c) +: 8];
      lc1[c] <= light_rgb[8*(2-c) +: 8] * 8'd255;
      m1[c]  <= material_rgb[8*(2-c) +: 8] * 8'd255;
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      p2[c]   = dif1_a * ml1[c];
      p3[c]   = sp1_a * lc1[c];
      p4[c]   = dif2_a * m1[c];
      p5[c]   = sp2_a * SQ_255;
      tsum[c] = t1[c] + t2[c] + t3[c] + t4[c] + t5[c];
      pr[c]   = tt4[c] * RECIP_255;
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      t1[c]   <= 36'({am1[c], 15'b0});
      t2[c]   <= 36'({p2[c], 1'b0});
      t3[c]   <= 36'({p3[c], 1'b0});
      t4[c]   <= 36'(p4[c]);
      t5[c]   <= 36'(p5[c]);
      acc3[c] <= (tsum[c] > 36'(FULL)) ? FULL : tsum[c][31:0];
      tt4[c]  <= 17'((33'(acc3[c]) + 33'(HALF_BIAS)) >> 15);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done    <= 1'b0;
      covered <= 1'b0;
    end else begin
      done    <= tag4_r.valid;
      covered <= tag4_r.valid && tag4_r.cov;
    end
  end

  always_ff @(posedge clk) begin
    red   <= tag4_r.cov ? pr[0][31:24] : '0;
    green <= tag4_r.cov ? pr[1][31:24] : '0;
    blue  <= tag4_r.cov ? pr[2][31:24] : '0;
  end

  `SPPX_ASSERT_NOW(a_uncov_black, done && !covered, red == '0 && green == '0 && blue == '0)
  `SPPX_ASSERT_NOW(a_cov_strobe, covered, done)
  `SPPX_ASSERT_NOW(a_done_src, done, $past(start && !busy, LAT))
  `SPPX_ASSERT_NEXT(a_rad_zero, d2_1 > (2*PIX_W)'(rr1), rad2 == '0)

endmodule

/* sim/tb_sphere_phong_pixel_shader_unit.sv */
`timescale 1ns / 100ps

module tb_sphere_phong_pixel_shader_unit;
  import sppx_pkg::*;

  typedef struct {
    logic       cov;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } shade_t;

  typedef struct {
    bit                    is_cfg;
    cfg_reg_t              idx;
    logic [RGB_W-1:0]      data;
    logic signed [PIX_W-1:0] x;
    logic signed [PIX_W-1:0] y;
    bit                    typed;
    shade_t                want;
  } row_t;

  localparam longint Q1 = 16384;
  localparam int WATCHDOG = 2000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic signed [PIX_W-1:0] pixel_x = '0;
  logic signed [PIX_W-1:0] pixel_y = '0;
  logic cfg_valid = 1'b0;
  logic [CIDX_W-1:0] cfg_index = '0;
  logic [RGB_W-1:0] cfg_data = '0;
  logic busy, cfg_ready, done, covered;
  logic [COL_W-1:0] red, green, blue;

  logic [RAD_W-1:0] m_radius = RST_RADIUS;
  logic signed [LPOS_W-1:0] m_lx = RST_LIGHT_X;
  logic signed [LPOS_W-1:0] m_ly = RST_LIGHT_Y;
  logic signed [LPOS_W-1:0] m_lz = RST_LIGHT_Z;
  logic [RGB_W-1:0] m_mat = RST_MATERIAL;
  logic [RGB_W-1:0] m_lrgb = RST_LIGHT;
  logic [RGB_W-1:0] m_amb = RST_AMBIENT;

  shade_t shade_q[$];
  row_t rows[$];
  int errs = 0;
  int idle_cnt = 0;

  always #1 clk = ~clk;

  sphere_phong_pixel_shader_unit u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .pixel_x(pixel_x), .pixel_y(pixel_y),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .done(done), .covered(covered),
    .red(red), .green(green), .blue(blue)
  );

  function automatic longint unsigned isqrt(input longint unsigned v);
    longint unsigned res, bt;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > v) bt >>= 2;
    while (bt != 0) begin
      if (v >= res + bt) begin
        v -= res + bt;
        res = (res >> 1) + bt;
      end else begin
        res >>= 1;
      end
      bt >>= 2;
    end
    return res;
  endfunction

  function automatic void norm3(input longint v[3], output longint u[3]);
    longint unsigned sq, len, mag, q;
    sq = 0;
    for (int i = 0; i < 3; i++) sq += longint'(v[i] * v[i]);
    len = isqrt(sq);
    for (int i = 0; i < 3; i++) begin
      if (len == 0) begin
        u[i] = 0;
      end else begin
        mag = v[i] < 0 ? -v[i] : v[i];
        q = (mag * Q1 * 2 + len) / (2 * len);
        u[i] = v[i] < 0 ? -longint'(q) : longint'(q);
      end
    end
  endfunction

  function automatic longint dot3(input longint a[3], input longint b[3]);
    return (a[0] * b[0] + a[1] * b[1] + a[2] * b[2]) / Q1;
  endfunction

  // reflect l about n, dot with view, clamp to [0, 1], raise to the 25th
  function automatic longint spec25(input longint n[3], input longint l[3],
                                    input longint d, input longint v[3]);
    longint refl[3];
    longint s, p;
    for (int i = 0; i < 3; i++) refl[i] = (2 * d * n[i]) / Q1 - l[i];
    s = dot3(refl, v);
    if (s < 0) s = 0;
    if (s > Q1) s = Q1;
    p = s;
    for (int i = 0; i < 24; i++) p = (p * s) / Q1;
    return p;
  endfunction

  function automatic shade_t shade_pixel(input logic signed [PIX_W-1:0] px,
                                         input logic signed [PIX_W-1:0] py);
    longint x, y, r, d2, z, dn, diff, sp, dn2, dif2, sp2, acc, full, m, lc, a;
    longint p[3], vv[3], n[3], v[3], l[3], l2[3];
    int sh;
    shade_t o;
    x = px;
    y = py;
    r = m_radius;
    d2 = x * x + y * y;
    full = longint'(2 * 255 * 255) * Q1;
    o = '{1'b0, 8'd0, 8'd0, 8'd0};
    if (d2 > r * r) return o;
    z = isqrt(longint'(r * r - d2) << 16);
    p = '{x * 256, y * 256, z};
    norm3(p, n);
    vv = '{-p[0], -p[1], 5 * r * 256 - z};
    norm3(vv, v);
    vv = '{longint'(m_lx) * 256 - p[0], longint'(m_ly) * 256 - p[1],
           longint'(m_lz) * 256 - z};
    norm3(vv, l);
    dn = dot3(n, l);
    diff = dn < 0 ? 0 : dn;
    sp = spec25(n, l, dn, v);
    vv = '{2 * r * 256 - p[0], -r * 256 - p[1], -z};
    norm3(vv, l2);
    dn2 = dot3(n, l2);
    dif2 = 0;
    sp2 = 0;
    if (dn2 >= 0) begin
      dif2 = dn2;
      sp2 = spec25(n, l2, dn2, v);
    end
    o.cov = 1'b1;
    for (int c = 0; c < 3; c++) begin
      sh = 16 - 8 * c;
      m = (m_mat >> sh) & 255;
      lc = (m_lrgb >> sh) & 255;
      a = (m_amb >> sh) & 255;
      acc = 2 * a * m * Q1 + 2 * diff * m * lc + 2 * sp * lc * 255
          + dif2 * m * 255 + sp2 * 255 * 255;
      if (acc < 0) acc = 0;
      if (acc > full) acc = full;
      acc = (acc * 510 + full) / (2 * full);
      if (c == 0) o.r = acc[7:0];
      else if (c == 1) o.g = acc[7:0];
      else o.b = acc[7:0];
    end
    return o;
  endfunction

  task automatic drain();
    start <= 1'b0;
    while (shade_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [RGB_W-1:0] data);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_RADIUS:   m_radius = data[RAD_W-1:0];
      REG_LIGHT_X:  m_lx = data[LPOS_W-1:0];
      REG_LIGHT_Y:  m_ly = data[LPOS_W-1:0];
      REG_LIGHT_Z:  m_lz = data[LPOS_W-1:0];
      REG_MATERIAL: m_mat = data;
      REG_LIGHT:    m_lrgb = data;
      REG_AMBIENT:  m_amb = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_pix(input logic signed [PIX_W-1:0] x,
                          input logic signed [PIX_W-1:0] y,
                          input bit typed, input shade_t want);
    start <= 1'b1;
    pixel_x <= x;
    pixel_y <= y;
    do @(posedge clk); while (busy);
    shade_q.push_back(typed ? want : shade_pixel(x, y));
  endtask

  task automatic idle(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic add_cfg(input cfg_reg_t idx, input logic [RGB_W-1:0] data);
    row_t rw;
    rw = '{1'b1, idx, data, '0, '0, 1'b0, '{1'b0, 8'd0, 8'd0, 8'd0}};
    rows.push_back(rw);
  endtask

  task automatic add_pix(input int x, input int y, input bit typed);
    row_t rw;
    rw = '{1'b0, REG_RADIUS, '0, x[PIX_W-1:0], y[PIX_W-1:0], typed,
           '{1'b0, 8'd0, 8'd0, 8'd0}};
    rows.push_back(rw);
  endtask

  // checker and watchdog
  always @(posedge clk) begin
    shade_t e;
    if (!rst) begin
      if ((start && !busy) || done || (cfg_valid && cfg_ready)) idle_cnt <= 0;
      else idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= WATCHDOG) begin
        $display("TB_ERROR");
        $finish;
      end
      if (done) begin
        if (shade_q.size() == 0) begin
          $error("result with nothing expected");
          errs++;
        end else begin
          e = shade_q.pop_front();
          if (covered !== e.cov) begin
            $error("covered exp %0d got %0d", e.cov, covered); errs++;
          end
          if (red !== e.r) begin
            $error("red exp %0d got %0d", e.r, red); errs++;
          end
          if (green !== e.g) begin
            $error("green exp %0d got %0d", e.g, green); errs++;
          end
          if (blue !== e.b) begin
            $error("blue exp %0d got %0d", e.b, blue); errs++;
          end
        end
      end
    end
  end

  initial begin
    int r, n, mode;
    bit calm;
    logic signed [PIX_W-1:0] x, y;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset setup
    add_pix(300, 0, 1);
    add_pix(0, 0, 0);
    add_pix(200, 0, 0);
    add_pix(-200, 0, 0);
    add_pix(0, -200, 0);
    add_pix(141, 141, 0);
    add_pix(1023, 1023, 1);
    add_pix(-1023, -1023, 1);
    // light sitting on the surface point
    add_cfg(REG_LIGHT_X, 24'd0);
    add_cfg(REG_LIGHT_Y, 24'd0);
    add_cfg(REG_LIGHT_Z, 24'd200);
    add_pix(0, 0, 0);
    // zero radius
    add_cfg(REG_RADIUS, 24'd0);
    add_pix(0, 0, 0);
    add_pix(1, 0, 1);
    add_pix(0, -1, 1);
    // largest radius, extreme light, white colours
    add_cfg(REG_RADIUS, 24'd1023);
    add_cfg(REG_LIGHT_X, 24'h1000);
    add_cfg(REG_LIGHT_Y, 24'h0FFF);
    add_cfg(REG_LIGHT_Z, 24'h1000);
    add_cfg(REG_MATERIAL, 24'hFFFFFF);
    add_cfg(REG_LIGHT, 24'hFFFFFF);
    add_cfg(REG_AMBIENT, 24'hFFFFFF);
    add_pix(1023, 0, 0);
    add_pix(-1023, 0, 0);
    add_pix(0, 1023, 0);
    add_pix(0, -1023, 0);
    add_pix(700, -700, 0);
    add_pix(723, 723, 0);
    add_pix(724, 724, 1);
    // unit radius, far light, black colours
    add_cfg(REG_RADIUS, 24'd1);
    add_cfg(REG_LIGHT_X, 24'h0FFF);
    add_cfg(REG_LIGHT_Y, 24'h0FFF);
    add_cfg(REG_LIGHT_Z, 24'h0FFF);
    add_cfg(REG_MATERIAL, 24'h000000);
    add_cfg(REG_LIGHT, 24'h000000);
    add_cfg(REG_AMBIENT, 24'h000000);
    add_pix(0, 0, 0);
    add_pix(1, 0, 0);
    add_pix(1, 1, 1);
    add_pix(-1, 0, 0);

    foreach (rows[i]) begin
      if (rows[i].is_cfg) write_reg(rows[i].idx, rows[i].data);
      else send_pix(rows[i].x, rows[i].y, rows[i].typed, rows[i].want);
    end

    // random setups, mostly pixels near or on the sphere
    for (int ph = 0; ph < 12; ph++) begin
      mode = $urandom_range(0, 9);
      r = mode == 0 ? 1 : mode == 1 ? 1023 : $urandom_range(1, 1023);
      write_reg(REG_RADIUS, 24'(r));
      write_reg(REG_LIGHT_X, 24'($urandom));
      write_reg(REG_LIGHT_Y, 24'($urandom));
      write_reg(REG_LIGHT_Z, 24'($urandom));
      write_reg(REG_MATERIAL, 24'($urandom));
      write_reg(REG_LIGHT, 24'($urandom));
      write_reg(REG_AMBIENT, 24'($urandom));
      calm = ph >= 10 || $urandom_range(0, 3) == 0;
      for (n = 0; n < 130; n++) begin
        if ($urandom_range(0, 9) == 0) begin
          x = PIX_W'($urandom_range(0, 2046) - 1023);
          y = PIX_W'($urandom_range(0, 2046) - 1023);
        end else begin
          x = PIX_W'($urandom_range(0, 2 * r) - r);
          y = PIX_W'($urandom_range(0, 2 * r) - r);
        end
        send_pix(x, y, 1'b0, '{1'b0, 8'd0, 8'd0, 8'd0});
        if (!calm && $urandom_range(0, 7) == 0) idle($urandom_range(1, 16));
        if (ph == 5 && n == 60) drain();
      end
    end

    drain();
    repeat (120) @(posedge clk);
    if (errs == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
